FILE: src/cit_pkg.sv
package cit_pkg;

    localparam int DEG_W   = 24;
    localparam int PULSE_W = 20;
    localparam int AR_W    = DEG_W + 2;
    localparam int PROD_W  = 2 * AR_W;
    localparam int DIV_CW  = $clog2(PROD_W);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_D2P   = 2'd1;
    localparam logic [1:0] OP_P2D   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FEW   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] CFG_CENTER = 2'd0;
    localparam logic [1:0] CFG_MIN    = 2'd1;
    localparam logic [1:0] CFG_MAX    = 2'd2;

    localparam logic [PULSE_W-1:0] CENTER_RST = 20'd384000;
    localparam logic [PULSE_W-1:0] MIN_RST    = 20'd128000;
    localparam logic [PULSE_W-1:0] MAX_RST    = 20'd640000;

    typedef struct packed {
        logic [1:0]               opcode;
        logic                     table_select;
        logic signed [DEG_W-1:0]  point_deg;
        logic [PULSE_W-1:0]       point_pulse;
    } cit_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [PULSE_W-1:0]       result_pulse;
        logic signed [DEG_W-1:0]  result_deg;
    } cit_out_t;

    typedef struct packed {
        logic signed [DEG_W-1:0]  fd;
        logic [PULSE_W-1:0]       fp;
        logic signed [DEG_W-1:0]  rd;
        logic [PULSE_W-1:0]       rp;
    } entry_t;

    typedef struct packed {
        logic                     found;
        logic signed [DEG_W-1:0]  d0;
        logic signed [DEG_W-1:0]  d1;
        logic [PULSE_W-1:0]       p0;
        logic [PULSE_W-1:0]       p1;
    } pkt_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UPD,
        WR_INS
    } wr_mode_t;

    typedef struct packed {
        wr_mode_t                 wr_mode;
        logic                     rev;
        logic                     walk;
        logic                     q_pulse;
        logic signed [DEG_W-1:0]  deg;
        logic [PULSE_W-1:0]       pulse;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_PICK,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } state_t;

    function automatic logic signed [AR_W-1:0] ext_d(input logic signed [DEG_W-1:0] d);
        ext_d = $signed({{(AR_W - DEG_W){d[DEG_W-1]}}, d});
    endfunction

    function automatic logic signed [AR_W-1:0] ext_p(input logic [PULSE_W-1:0] p);
        ext_p = $signed({{(AR_W - PULSE_W){1'b0}}, p});
    endfunction

endpackage

FILE: src/cit_cell.sv
module cit_cell #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX = 0
) (
    input  logic                                 clk,
    input  cit_pkg::cmd_t                        cmd,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     cnt,
    input  cit_pkg::entry_t                      left_ent,
    input  cit_pkg::entry_t                      right_ent,
    input  logic                                 left_gt,
    output cit_pkg::entry_t                      ent,
    output logic                                 gt,
    output logic                                 eq,
    input  cit_pkg::pkt_t                        a_in,
    input  cit_pkg::pkt_t                        b_in,
    input  cit_pkg::pkt_t                        l_in,
    output cit_pkg::pkt_t                        a_out,
    output cit_pkg::pkt_t                        b_out,
    output cit_pkg::pkt_t                        l_out
);
    import cit_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t ent_reg, ent_next;
    pkt_t   a_reg, a_next, b_reg, b_next, l_reg, l_next, own;

    logic signed [DEG_W-1:0] my_d, nb_d, ld, new_d;
    logic [PULSE_W-1:0]      my_p, nb_p, lp, new_p;
    logic valid, seg_ok, is_last, ha, hb;

    always_comb
    begin
        my_d = cmd.rev ? ent_reg.rd : ent_reg.fd;
        my_p = cmd.rev ? ent_reg.rp : ent_reg.fp;
        nb_d = cmd.rev ? right_ent.rd : right_ent.fd;
        nb_p = cmd.rev ? right_ent.rp : right_ent.fp;
        ld   = cmd.rev ? left_ent.rd : left_ent.fd;
        lp   = cmd.rev ? left_ent.rp : left_ent.fp;

        valid   = CW'(IDX) < cnt;
        seg_ok  = CW'(IDX + 1) < cnt;
        is_last = CW'(IDX + 1) == cnt;
        gt      = valid && (my_d < cmd.deg);
        eq      = valid && (my_d == cmd.deg);

        new_d = my_d;
        new_p = my_p;
        case (cmd.wr_mode)
            WR_UPD:
            begin
                if (eq)
                begin
                    new_p = cmd.pulse;
                end
            end
            WR_INS:
            begin
                // Entries below the insertion point stay; the first entry at or
                // above it takes the new point, the rest move up by one.
                if (!gt)
                begin
                    if (left_gt)
                    begin
                        new_d = cmd.deg;
                        new_p = cmd.pulse;
                    end
                    else
                    begin
                        new_d = ld;
                        new_p = lp;
                    end
                end
            end
            default:
            begin
            end
        endcase

        ent_next = ent_reg;
        if (cmd.rev)
        begin
            ent_next.rd = new_d;
            ent_next.rp = new_p;
        end
        else
        begin
            ent_next.fd = new_d;
            ent_next.fp = new_p;
        end

        ha = seg_ok && (cmd.q_pulse ? (my_p <= cmd.pulse && cmd.pulse <= nb_p)
                                    : (my_d <= cmd.deg && cmd.deg <= nb_d));
        hb = seg_ok && cmd.q_pulse && (nb_p <= cmd.pulse && cmd.pulse <= my_p);

        own.found = 1'b1;
        own.d0    = my_d;
        own.d1    = nb_d;
        own.p0    = my_p;
        own.p1    = nb_p;

        // Hits flow toward cell zero, so the lowest matching segment wins.
        a_next = a_reg;
        b_next = b_reg;
        l_next = l_reg;
        if (cmd.walk)
        begin
            a_next = ha ? own : a_in;
            b_next = hb ? own : b_in;
            l_next = is_last ? own : l_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        l_reg   <= l_next;
    end

    assign ent   = ent_reg;
    assign a_out = a_reg;
    assign b_out = b_reg;
    assign l_out = l_reg;

endmodule

FILE: src/cit_div.sv
module cit_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cit_pkg::PROD_W-1:0]    dvd,
    input  logic [cit_pkg::AR_W-1:0]      dvs,
    output logic                          done,
    output logic [cit_pkg::AR_W-1:0]      quo
);
    import cit_pkg::*;

    logic                run_reg, run_next, done_reg, done_next;
    logic [DIV_CW-1:0]   step_reg, step_next;
    logic [AR_W-1:0]     rem_reg, rem_next, dvs_reg, dvs_next;
    logic [PROD_W-1:0]   q_reg, q_next;
    logic [AR_W:0]       trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        trial     = {rem_reg, q_reg[PROD_W-1]};
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = dvs;
            q_next    = dvd;
        end
        else if (run_reg)
        begin
            // One quotient bit per cycle, restoring form.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = AR_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[AR_W-1:0];
                q_next   = {q_reg[PROD_W-2:0], 1'b0};
            end
            step_next = step_reg + DIV_CW'(1);
            if (step_reg == DIV_CW'(PROD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg[AR_W-1:0];

endmodule

FILE: src/calibration_table_interpolator_top.sv
// Keeps a forward and a reverse calibration table of angle/pulse points in a row of
// TABLE_DEPTH cells, one point per cell per table, sorted by angle. One item is worked
// on at a time, and the next is taken in the cycle after its result is registered for
// output. A write, an opcode three item or a query on a table with fewer than two points
// passes from S_EXEC to S_OUT and then into the output register. A query walks the cell
// chain in S_WALK. A query that clamps at an end point, lands on a flat segment or finds
// no segment then goes from S_PICK straight to S_OUT. Any other query then takes a
// multiply step in S_MUL and a bit-serial divide of 52 quotient bits before S_OUT. While
// a result waits on a stalled output, the input stays stalled.
module calibration_table_interpolator_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cit_pkg::cit_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cit_pkg::cit_out_t           out_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [cit_pkg::PULSE_W-1:0] cfg_data
);
    import cit_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t   state_reg, state_next;
    cit_in_t  item_reg, item_next;
    cit_out_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    logic [CW-1:0] fwd_cnt_reg, fwd_cnt_next, rev_cnt_reg, rev_cnt_next;
    logic [CW-1:0] walk_reg, walk_next, cnt_sel;
    logic [PULSE_W-1:0] center_reg, min_reg, max_reg;
    logic [1:0] st_reg, st_next;
    logic signed [AR_W-1:0] res_reg, res_next, y0_reg, y0_next, off_reg, off_next;
    logic signed [AR_W-1:0] span_reg, span_next, wid_reg, wid_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    cmd_t   cmd;
    logic   sel_rev, any_eq, div_start, div_done, neg;
    logic [TABLE_DEPTH-1:0] gt_w, eq_w;
    entry_t ent_w [TABLE_DEPTH];
    pkt_t   a_w [TABLE_DEPTH];
    pkt_t   b_w [TABLE_DEPTH];
    pkt_t   l_w [TABLE_DEPTH];
    logic [PROD_W-1:0] dvd_mag;
    logic [AR_W-1:0]   dvs_mag, quo;
    logic signed [AR_W-1:0] c0d, c0p, lastd, lastp, qs;
    pkt_t   pk;
    logic   direct, rising;
    logic signed [AR_W-1:0] dres;

    assign sel_rev = (item_reg.opcode == OP_P2D) ? 1'b0 : item_reg.table_select;
    assign cnt_sel = sel_rev ? rev_cnt_reg : fwd_cnt_reg;
    assign any_eq  = |eq_w;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t le, re;
            logic   lg;
            pkt_t   ai, bi, li;
            if (gi == 0)
            begin : g_first
                assign le = '0;
                assign lg = 1'b1;
            end
            else
            begin : g_mid
                assign le = ent_w[gi-1];
                assign lg = gt_w[gi-1];
            end
            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign re = '0;
                assign ai = '0;
                assign bi = '0;
                assign li = '0;
            end
            else
            begin : g_inner
                assign re = ent_w[gi+1];
                assign ai = a_w[gi+1];
                assign bi = b_w[gi+1];
                assign li = l_w[gi+1];
            end
            cit_cell #(
                .TABLE_DEPTH(TABLE_DEPTH),
                .IDX(gi)
            ) u_cell (
                .clk(clk),
                .cmd(cmd),
                .cnt(cnt_sel),
                .left_ent(le),
                .right_ent(re),
                .left_gt(lg),
                .ent(ent_w[gi]),
                .gt(gt_w[gi]),
                .eq(eq_w[gi]),
                .a_in(ai),
                .b_in(bi),
                .l_in(li),
                .a_out(a_w[gi]),
                .b_out(b_w[gi]),
                .l_out(l_w[gi])
            );
        end
    endgenerate

    assign neg     = prod_reg[PROD_W-1] ^ wid_reg[AR_W-1];
    assign dvd_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign dvs_mag = wid_reg[AR_W-1] ? AR_W'(-wid_reg) : AR_W'(wid_reg);
    assign qs      = neg ? -$signed(quo) : $signed(quo);

    cit_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dvd(dvd_mag),
        .dvs(dvs_mag),
        .done(div_done),
        .quo(quo)
    );

    // End-point clamps and segment choice once the chain walk is complete.
    always_comb
    begin
        c0d    = ext_d(sel_rev ? ent_w[0].rd : ent_w[0].fd);
        c0p    = ext_p(sel_rev ? ent_w[0].rp : ent_w[0].fp);
        lastd  = ext_d(l_w[0].d0);
        lastp  = ext_p(l_w[0].p0);
        rising = lastp >= c0p;
        direct = 1'b1;
        dres   = lastd;
        pk     = a_w[0];
        if (item_reg.opcode == OP_D2P)
        begin
            dres = lastp;
            if (ext_d(item_reg.point_deg) <= c0d)
            begin
                dres = c0p;
            end
            else if (ext_d(item_reg.point_deg) >= lastd)
            begin
                dres = lastp;
            end
            else if (pk.found)
            begin
                direct = 1'b0;
            end
        end
        else
        begin
            if (!rising)
            begin
                pk = b_w[0];
            end
            if (rising ? (ext_p(item_reg.point_pulse) <= c0p)
                       : (ext_p(item_reg.point_pulse) >= c0p))
            begin
                dres = c0d;
            end
            else if (rising ? (ext_p(item_reg.point_pulse) >= lastp)
                            : (ext_p(item_reg.point_pulse) <= lastp))
            begin
                dres = lastd;
            end
            else if (pk.found)
            begin
                if (pk.p0 == pk.p1)
                begin
                    // A flat segment answers with its first angle.
                    dres = ext_d(pk.d0);
                end
                else
                begin
                    direct = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        fwd_cnt_next   = fwd_cnt_reg;
        rev_cnt_next   = rev_cnt_reg;
        walk_next      = walk_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        y0_next        = y0_reg;
        off_next       = off_reg;
        span_next      = span_reg;
        wid_next       = wid_reg;
        prod_next      = prod_reg;
        div_start      = 1'b0;

        cmd.wr_mode = WR_NONE;
        cmd.rev     = sel_rev;
        cmd.walk    = 1'b0;
        cmd.q_pulse = (item_reg.opcode == OP_P2D);
        cmd.deg     = item_reg.point_deg;
        cmd.pulse   = item_reg.point_pulse;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next    = ST_OK;
                res_next   = '0;
                state_next = S_OUT;
                unique case (item_reg.opcode) inside
                    OP_WRITE:
                    begin
                        if (item_reg.point_pulse < min_reg || item_reg.point_pulse > max_reg)
                        begin
                            st_next = ST_RANGE;
                        end
                        else if (any_eq)
                        begin
                            cmd.wr_mode = WR_UPD;
                            st_next     = (cnt_sel < CW'(2)) ? ST_FEW : ST_OK;
                        end
                        else if (cnt_sel == CW'(TABLE_DEPTH))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_mode = WR_INS;
                            st_next     = (cnt_sel == '0) ? ST_FEW : ST_OK;
                            if (sel_rev)
                            begin
                                rev_cnt_next = rev_cnt_reg + CW'(1);
                            end
                            else
                            begin
                                fwd_cnt_next = fwd_cnt_reg + CW'(1);
                            end
                        end
                    end
                    OP_D2P, OP_P2D:
                    begin
                        if (cnt_sel < CW'(2))
                        begin
                            st_next  = ST_FEW;
                            res_next = (item_reg.opcode == OP_D2P) ? ext_p(center_reg) : '0;
                        end
                        else
                        begin
                            walk_next  = '0;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.walk  = 1'b1;
                walk_next = walk_reg + CW'(1);
                if (walk_reg == CW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (direct)
                begin
                    res_next   = dres;
                    state_next = S_OUT;
                end
                else
                begin
                    if (item_reg.opcode == OP_D2P)
                    begin
                        y0_next   = ext_p(pk.p0);
                        off_next  = ext_d(item_reg.point_deg) - ext_d(pk.d0);
                        span_next = ext_p(pk.p1) - ext_p(pk.p0);
                        wid_next  = ext_d(pk.d1) - ext_d(pk.d0);
                    end
                    else
                    begin
                        y0_next   = ext_d(pk.d0);
                        off_next  = ext_p(item_reg.point_pulse) - ext_p(pk.p0);
                        span_next = ext_d(pk.d1) - ext_d(pk.d0);
                        wid_next  = ext_p(pk.p1) - ext_p(pk.p0);
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = off_reg * span_reg;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    res_next   = y0_reg + qs;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = st_reg;
                    out_next.result_pulse = (item_reg.opcode == OP_D2P) ?
                                            res_reg[PULSE_W-1:0] : '0;
                    out_next.result_deg   = (item_reg.opcode == OP_P2D) ?
                                            $signed(res_reg[DEG_W-1:0]) : '0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fwd_cnt_reg   <= '0;
            rev_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fwd_cnt_reg   <= fwd_cnt_next;
            rev_cnt_reg   <= rev_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RST;
            min_reg    <= MIN_RST;
            max_reg    <= MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER: center_reg <= cfg_data;
                CFG_MIN:    min_reg    <= cfg_data;
                CFG_MAX:    max_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
        walk_reg <= walk_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
        y0_reg   <= y0_next;
        off_reg  <= off_next;
        span_reg <= span_next;
        wid_reg  <= wid_next;
        prod_reg <= prod_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: tb/sv/calibration_table_interpolator_top_tb.sv
`timescale 1ns / 1ps

module calibration_table_interpolator_top_tb;
    import cit_pkg::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    cit_in_t in_data;
    logic out_valid;
    logic out_stall;
    cit_out_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [PULSE_W-1:0] cfg_data;

    calibration_table_interpolator_top #(.TABLE_DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Calibration state as predicted, index 0 forward and 1 reverse.
    int cal_deg [2][DEPTH];
    int cal_pulse [2][DEPTH];
    int point_cnt [2];
    int center_val;
    int min_val;
    int max_val;

    cit_in_t pending_items[$];
    cit_out_t expected_results[$];

    int errors = 0;
    int cycles = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    logic hold_request;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int lerp_val(longint y0, longint y1, longint off, longint width);
        if (width == 0)
            return int'(y0);
        return int'(y0 + (off * (y1 - y0)) / width);
    endfunction

    function automatic cit_out_t predict_result(cit_in_t item);
        cit_out_t r;
        int t;
        int n;
        int deg;
        int p;
        int pos;
        bit found;
        bit rising;
        r = '0;
        t = item.table_select;
        deg = item.point_deg;
        p = item.point_pulse;
        case (item.opcode)
            OP_WRITE:
            begin
                n = point_cnt[t];
                found = 0;
                if (p < min_val || p > max_val)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = 0; i < n; i++)
                        if (!found && cal_deg[t][i] == deg)
                        begin
                            cal_pulse[t][i] = p;
                            found = 1;
                        end
                    if (!found && n >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (!found)
                        begin
                            pos = 0;
                            while (pos < n && cal_deg[t][pos] < deg)
                                pos++;
                            for (int i = n; i > pos; i--)
                            begin
                                cal_deg[t][i] = cal_deg[t][i-1];
                                cal_pulse[t][i] = cal_pulse[t][i-1];
                            end
                            cal_deg[t][pos] = deg;
                            cal_pulse[t][pos] = p;
                            n++;
                            point_cnt[t] = n;
                        end
                        r.status = (n < 2) ? ST_FEW : ST_OK;
                    end
                end
            end
            OP_D2P:
            begin
                n = point_cnt[t];
                if (n < 2)
                begin
                    r.status = ST_FEW;
                    r.result_pulse = PULSE_W'(center_val);
                end
                else if (deg <= cal_deg[t][0])
                    r.result_pulse = PULSE_W'(cal_pulse[t][0]);
                else if (deg >= cal_deg[t][n-1])
                    r.result_pulse = PULSE_W'(cal_pulse[t][n-1]);
                else
                begin
                    found = 0;
                    for (int i = 0; i + 1 < n; i++)
                        if (!found && deg >= cal_deg[t][i] && deg <= cal_deg[t][i+1])
                        begin
                            r.result_pulse = PULSE_W'(lerp_val(cal_pulse[t][i],
                                cal_pulse[t][i+1],
                                longint'(deg) - cal_deg[t][i],
                                longint'(cal_deg[t][i+1]) - cal_deg[t][i]));
                            found = 1;
                        end
                end
            end
            OP_P2D:
            begin
                n = point_cnt[0];
                if (n < 2)
                    r.status = ST_FEW;
                else
                begin
                    rising = cal_pulse[0][n-1] >= cal_pulse[0][0];
                    found = 1;
                    if (rising ? (p <= cal_pulse[0][0]) : (p >= cal_pulse[0][0]))
                        r.result_deg = DEG_W'(cal_deg[0][0]);
                    else if (rising ? (p >= cal_pulse[0][n-1]) : (p <= cal_pulse[0][n-1]))
                        r.result_deg = DEG_W'(cal_deg[0][n-1]);
                    else
                        found = 0;
                    for (int i = 0; i + 1 < n; i++)
                        if (!found && (rising
                            ? (p >= cal_pulse[0][i] && p <= cal_pulse[0][i+1])
                            : (p <= cal_pulse[0][i] && p >= cal_pulse[0][i+1])))
                        begin
                            r.result_deg = DEG_W'(lerp_val(cal_deg[0][i], cal_deg[0][i+1],
                                longint'(p) - cal_pulse[0][i],
                                longint'(cal_pulse[0][i+1]) - cal_pulse[0][i]));
                            found = 1;
                        end
                    if (!found)
                        r.result_deg = DEG_W'(cal_deg[0][n-1]);
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Driver: presents the oldest pending item and predicts it once accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_result(in_data));
                void'(pending_items.pop_front());
            end
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pending_items[0];
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold, loaded on request and counted down here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_request)
            hold_cycles <= 600;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor: checks results and drives the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    if (out_data.status !== expected_results[0].status)
                        report_mismatch("status", out_data.status,
                                        expected_results[0].status);
                    if (out_data.result_pulse !== expected_results[0].result_pulse)
                        report_mismatch("result_pulse", out_data.result_pulse,
                                        expected_results[0].result_pulse);
                    if (out_data.result_deg !== expected_results[0].result_deg)
                        report_mismatch("result_deg", out_data.result_deg,
                                        expected_results[0].result_deg);
                    void'(expected_results.pop_front());
                end
            end
            if (hold_cycles > 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic cit_in_t make_item(logic [1:0] op, logic sel, int deg, int p);
        cit_in_t it;
        it.opcode = op;
        it.table_select = sel;
        it.point_deg = DEG_W'(deg);
        it.point_pulse = PULSE_W'(p);
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 70) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= PULSE_W'(value);
        case (idx)
            CFG_CENTER: center_val = value;
            CFG_MIN: min_val = value;
            default: max_val = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_deg(int spread);
        return $urandom_range(spread) - spread / 2;
    endfunction

    // One random item, mostly inside the clamp range and near stored angles.
    task automatic queue_random_item();
        int r;
        int t;
        int deg;
        int p;
        r = $urandom_range(99);
        t = $urandom_range(1);
        if ($urandom_range(9) == 0)
            deg = $urandom;
        else if (point_cnt[t] > 0 && $urandom_range(3) == 0)
            deg = cal_deg[t][$urandom_range(point_cnt[t] - 1)];
        else
            deg = rand_deg(40000);
        if ($urandom_range(9) == 0)
            p = $urandom_range(20'hFFFFF);
        else if (min_val <= max_val)
            p = $urandom_range(max_val, min_val);
        else
            p = $urandom_range(20'hFFFFF);
        if (r < 40)
            pending_items.push_back(make_item(OP_WRITE, t, deg, p));
        else if (r < 70)
            pending_items.push_back(make_item(OP_D2P, t, deg, p));
        else if (r < 97)
            pending_items.push_back(make_item(OP_P2D, t, deg, p));
        else
            pending_items.push_back(make_item(OP_UNUSED, t, deg, p));
    endtask

    initial
    begin
        hold_request = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 66;
        cfg_we = 1'b0;
        cfg_index = CFG_CENTER;
        cfg_data = '0;
        center_val = CENTER_RST;
        min_val = MIN_RST;
        max_val = MAX_RST;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty and single-point tables, extremes, the unused opcode.
        pending_items.push_back(make_item(OP_D2P, 0, 0, 0));
        pending_items.push_back(make_item(OP_P2D, 1, 0, 200000));
        pending_items.push_back(make_item(OP_WRITE, 0, 0, 100));
        pending_items.push_back(make_item(OP_WRITE, 0, 0, 20'hFFFFF));
        pending_items.push_back(make_item(OP_WRITE, 0, 0, MIN_RST));
        pending_items.push_back(make_item(OP_D2P, 0, 5, 0));
        pending_items.push_back(make_item(OP_WRITE, 0, -8388608, MAX_RST));
        pending_items.push_back(make_item(OP_WRITE, 0, 8388607, MIN_RST));
        pending_items.push_back(make_item(OP_WRITE, 0, 0, 300000));
        pending_items.push_back(make_item(OP_D2P, 0, -8388608, 0));
        pending_items.push_back(make_item(OP_D2P, 0, 8388607, 0));
        pending_items.push_back(make_item(OP_D2P, 0, -1234567, 0));
        pending_items.push_back(make_item(OP_P2D, 0, 0, 0));
        pending_items.push_back(make_item(OP_P2D, 1, -1, 20'hFFFFF));
        pending_items.push_back(make_item(OP_P2D, 0, 0, 400000));
        pending_items.push_back(make_item(OP_WRITE, 0, 100, 300000));
        pending_items.push_back(make_item(OP_P2D, 0, 0, 300000));
        pending_items.push_back(make_item(OP_WRITE, 0, 200, 640000));
        pending_items.push_back(make_item(OP_P2D, 0, 0, 600000));
        pending_items.push_back(make_item(OP_UNUSED, 1, -1, 20'hFFFFF));
        pending_items.push_back(make_item(OP_WRITE, 1, 7, MAX_RST));
        pending_items.push_back(make_item(OP_D2P, 1, 7, 0));
        wait_drained();

        write_reg(CFG_CENTER, 20'hFFFFF);
        write_reg(CFG_MIN, 0);
        write_reg(CFG_MAX, 20'hFFFFF);
        for (int i = 0; i < 380; i++)
            queue_random_item();
        // Long receiver hold so the block backs up onto its input.
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        wait_drained();

        send_idle_pct = 66;
        recv_idle_pct = 35;
        write_reg(CFG_CENTER, 0);
        write_reg(CFG_MIN, 200000);
        write_reg(CFG_MAX, 100000);
        for (int i = 0; i < 60; i++)
            queue_random_item();
        wait_drained();
        write_reg(CFG_MIN, 100000);
        write_reg(CFG_MAX, 700000);
        for (int i = 0; i < 320; i++)
            queue_random_item();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_CENTER, 123456);
        write_reg(CFG_MIN, 0);
        write_reg(CFG_MAX, 20'hFFFFF);
        for (int i = 0; i < 340; i++)
            queue_random_item();
        wait_drained();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/cit_pkg.sv
src/cit_cell.sv
src/cit_div.sv
src/calibration_table_interpolator_top.sv
tb/sv/calibration_table_interpolator_top_tb.sv
